// File: hdl/assert_macros.svh
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the reset is released.
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/ppa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

  // Default number of physical pages.
  localparam int NumPagesDefault = 4096;

  // The ISA hole, 640 KiB up to 1 MiB, in 4 KiB pages.
  localparam logic [11:0] IsaFirstPage = 12'd160;
  localparam logic [11:0] IsaLastPage  = 12'd255;

  // Field widths.
  localparam int CmdW    = 2;
  localparam int PageW   = 12;
  localparam int CountW  = 13;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 13;

  // Command codes.
  localparam logic [CmdW-1:0] CmdAdd   = 2'd0;
  localparam logic [CmdW-1:0] CmdAlloc = 2'd1;
  localparam logic [CmdW-1:0] CmdFree  = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StOutOfMem = 2'd1;
  localparam logic [StatusW-1:0] StNoRun    = 2'd2;
  localparam logic [StatusW-1:0] StRejected = 2'd3;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegUsablePages = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKernelFirst = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKernelLast  = 2'd2;

  // Register reset values.
  localparam logic [CountW-1:0] UsablePagesReset = 13'd4096;
  localparam logic [PageW-1:0]  KernelFirstReset = 12'd256;
  localparam logic [PageW-1:0]  KernelLastReset  = 12'd511;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PG_RD,
    ST_PG_CHK,
    ST_ALLOC,
    ST_POP_RD,
    ST_POP_EV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_RUN_CLR,
    ST_UH_RD,
    ST_UH_EV,
    ST_UN_CHK,
    ST_UN_EV,
    ST_SK_EV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: hdl/physical_page_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Signals                           | Contents
// s_axis    | in        | tvalid, tready, tdata, tuser      | one command beat
// m_axis    | out       | tvalid, tready, tdata, tuser      | one result beat per command
// cfg       | in        | valid, ready, index, data         | register writes
//
// Add, free and a single-page allocate each go through their own states, each
// step waiting on the registered read of the free map or the link table.
// A run allocate scans pages, clears the pages of the run and walks list nodes
// while unlinking, all through the one shared read port of each memory.
// After reset a clearing pass writes the whole free map, while no command beat
// is taken; configuration writes are taken throughout.
// A finished result waits in the output register, and the next command is
// accepted meanwhile; only its own result waits for the slot to empty.

`include "assert_macros.svh"

module physical_page_allocator_top #(
  parameter int NUM_PAGES = ppa_pkg::NumPagesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [11:0] page, [24:12] page_count, [31:25] zero
  input  wire logic [31:0] s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [11:0] result_page, [24:12] free_count, [31:25] zero
  output logic      [31:0] m_axis_tdata_o,
  // [1:0] status
  output logic      [1:0]  m_axis_tuser_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);

  // Page index width, link width (one more, so the empty mark fits) and a
  // working width wide enough for page numbers, counts and the page total.
  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = PW + 1;
  localparam int WW = (LW > ppa_pkg::CountW) ? LW : ppa_pkg::CountW;
  localparam logic [LW-1:0] ListEmpty = LW'(NUM_PAGES);
  localparam logic [WW-1:0] NumPagesW = WW'(NUM_PAGES);

  ppa_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [ppa_pkg::CountW-1:0] usable_q;
  logic [ppa_pkg::PageW-1:0]  kfirst_q, klast_q;

  // Command held for the whole sequence.
  logic [ppa_pkg::CmdW-1:0]   cmd_q;
  logic [ppa_pkg::PageW-1:0]  page_q;
  logic [WW-1:0]              count_q;

  // Allocator state.
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] total_q, total_d;

  // Sequencer working registers.
  logic [WW-1:0] ptr_q, ptr_d;
  logic [WW-1:0] run_q, run_d;
  logic [PW-1:0] start_q, start_d;
  logic [PW-1:0] end_q, end_d;
  logic [LW-1:0] node_q, node_d;
  logic [ppa_pkg::StatusW-1:0] st_q, st_d;
  logic [PW-1:0] rp_q, rp_d;

  // Output register.
  logic                        out_valid_q;
  logic [ppa_pkg::StatusW-1:0] out_status_q;
  logic [ppa_pkg::PageW-1:0]   out_page_q;
  logic [ppa_pkg::CountW-1:0]  out_count_q;

  // Free map and link table, each with one write and one registered read port.
  logic          map_mem [NUM_PAGES];
  logic          map_we, map_wdata, map_rdata_q;
  logic [PW-1:0] map_waddr, map_raddr;
  logic [LW-1:0] link_mem [NUM_PAGES];
  logic          link_we;
  logic [PW-1:0] link_waddr, link_raddr;
  logic [LW-1:0] link_wdata, link_rdata_q;

  logic          accept;
  logic          out_free;
  logic [WW-1:0] page_w;
  logic [WW-1:0] limit;
  logic          reserved;
  logic          head_in_run, nxt_in_run;
  logic [WW-1:0] run_inc;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign page_w   = WW'(page_q);
  assign limit    = (WW'(usable_q) > NumPagesW) ? NumPagesW : WW'(usable_q);
  assign run_inc  = run_q + WW'(1);

  // An add never takes page 0, the ISA hole or the kernel image; a free does. A reversed
  // kernel range covers nothing, which the two compares give by themselves.
  assign reserved = (page_q == '0)
      || (page_q >= ppa_pkg::IsaFirstPage && page_q <= ppa_pkg::IsaLastPage)
      || (page_q >= kfirst_q && page_q <= klast_q);

  assign head_in_run = (head_q != ListEmpty) && (head_q >= LW'(start_q))
                       && (head_q <= LW'(end_q));
  assign nxt_in_run  = (link_rdata_q != ListEmpty) && (link_rdata_q >= LW'(start_q))
                       && (link_rdata_q <= LW'(end_q));

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {7'd0, out_count_q, out_page_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppa_pkg::ST_CLEAR: begin
        if (ptr_q == NumPagesW - WW'(1)) state_d = ppa_pkg::ST_IDLE;
      end
      ppa_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == ppa_pkg::CmdAdd || s_axis_tuser_i == ppa_pkg::CmdFree) begin
            state_d = ppa_pkg::ST_PG_RD;
          end else if (s_axis_tuser_i == ppa_pkg::CmdAlloc) begin
            state_d = ppa_pkg::ST_ALLOC;
          end else begin
            state_d = ppa_pkg::ST_DONE;
          end
        end
      end
      ppa_pkg::ST_PG_RD: begin
        state_d = (page_w >= NumPagesW) ? ppa_pkg::ST_DONE : ppa_pkg::ST_PG_CHK;
      end
      ppa_pkg::ST_PG_CHK: state_d = ppa_pkg::ST_DONE;
      ppa_pkg::ST_ALLOC: begin
        if (head_q == ListEmpty) state_d = ppa_pkg::ST_DONE;
        else if (count_q == WW'(1)) state_d = ppa_pkg::ST_POP_RD;
        else state_d = ppa_pkg::ST_SCAN_RD;
      end
      ppa_pkg::ST_POP_RD: state_d = ppa_pkg::ST_POP_EV;
      ppa_pkg::ST_POP_EV: state_d = ppa_pkg::ST_DONE;
      ppa_pkg::ST_SCAN_RD: begin
        state_d = (ptr_q >= limit) ? ppa_pkg::ST_DONE : ppa_pkg::ST_SCAN_EV;
      end
      ppa_pkg::ST_SCAN_EV: begin
        if (map_rdata_q && run_inc == count_q) state_d = ppa_pkg::ST_RUN_CLR;
        else state_d = ppa_pkg::ST_SCAN_RD;
      end
      ppa_pkg::ST_RUN_CLR: begin
        if (ptr_q[PW-1:0] == end_q) state_d = ppa_pkg::ST_UH_RD;
      end
      ppa_pkg::ST_UH_RD: state_d = head_in_run ? ppa_pkg::ST_UH_EV : ppa_pkg::ST_UN_CHK;
      ppa_pkg::ST_UH_EV: state_d = ppa_pkg::ST_UH_RD;
      ppa_pkg::ST_UN_CHK: begin
        state_d = (node_q == ListEmpty) ? ppa_pkg::ST_DONE : ppa_pkg::ST_UN_EV;
      end
      ppa_pkg::ST_UN_EV: state_d = nxt_in_run ? ppa_pkg::ST_SK_EV : ppa_pkg::ST_UN_CHK;
      ppa_pkg::ST_SK_EV: state_d = ppa_pkg::ST_UN_CHK;
      ppa_pkg::ST_DONE: begin
        if (out_free) state_d = ppa_pkg::ST_IDLE;
      end
      default: state_d = ppa_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    s_axis_tready_o = 1'b0;
    head_d     = head_q;
    total_d    = total_q;
    ptr_d      = ptr_q;
    run_d      = run_q;
    start_d    = start_q;
    end_d      = end_q;
    node_d     = node_q;
    st_d       = st_q;
    rp_d       = rp_q;
    map_we     = 1'b0;
    map_waddr  = ptr_q[PW-1:0];
    map_wdata  = 1'b0;
    map_raddr  = ptr_q[PW-1:0];
    link_we    = 1'b0;
    link_waddr = node_q[PW-1:0];
    link_wdata = link_rdata_q;
    link_raddr = head_q[PW-1:0];
    case (state_q)
      ppa_pkg::ST_CLEAR: begin
        map_we = 1'b1;
        ptr_d  = ptr_q + WW'(1);
      end
      ppa_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        st_d = ppa_pkg::StRejected;
        rp_d = '0;
      end
      ppa_pkg::ST_PG_RD: begin
        map_raddr = page_w[PW-1:0];
      end
      ppa_pkg::ST_PG_CHK: begin
        if (!map_rdata_q && (cmd_q == ppa_pkg::CmdFree || !reserved)) begin
          map_we     = 1'b1;
          map_waddr  = page_w[PW-1:0];
          map_wdata  = 1'b1;
          link_we    = 1'b1;
          link_waddr = page_w[PW-1:0];
          link_wdata = head_q;
          head_d     = LW'(page_w);
          total_d    = total_q + LW'(1);
          st_d       = ppa_pkg::StOk;
        end
      end
      ppa_pkg::ST_ALLOC: begin
        ptr_d = '0;
        run_d = '0;
        if (head_q == ListEmpty) st_d = ppa_pkg::StOutOfMem;
        else if (count_q != WW'(1)) st_d = ppa_pkg::StNoRun;
      end
      ppa_pkg::ST_POP_RD: begin
        link_raddr = head_q[PW-1:0];
      end
      ppa_pkg::ST_POP_EV: begin
        head_d    = link_rdata_q;
        map_we    = 1'b1;
        map_waddr = head_q[PW-1:0];
        total_d   = total_q - LW'(1);
        rp_d      = head_q[PW-1:0];
        st_d      = ppa_pkg::StOk;
      end
      ppa_pkg::ST_SCAN_RD: begin
        map_raddr = ptr_q[PW-1:0];
      end
      ppa_pkg::ST_SCAN_EV: begin
        if (!map_rdata_q) begin
          run_d = '0;
          ptr_d = ptr_q + WW'(1);
        end else begin
          run_d = run_inc;
          if (run_q == '0) start_d = ptr_q[PW-1:0];
          if (run_inc == count_q) begin
            // Run found: go back to its first page to clear it.
            end_d = ptr_q[PW-1:0];
            ptr_d = (run_q == '0) ? ptr_q : WW'(start_q);
          end else begin
            ptr_d = ptr_q + WW'(1);
          end
        end
      end
      ppa_pkg::ST_RUN_CLR: begin
        map_we = 1'b1;
        ptr_d  = ptr_q + WW'(1);
      end
      ppa_pkg::ST_UH_RD: begin
        link_raddr = head_q[PW-1:0];
        node_d     = head_q;
      end
      ppa_pkg::ST_UH_EV: begin
        head_d = link_rdata_q;
      end
      ppa_pkg::ST_UN_CHK: begin
        link_raddr = node_q[PW-1:0];
        if (node_q == ListEmpty) begin
          total_d = total_q - LW'(count_q);
          rp_d    = start_q;
          st_d    = ppa_pkg::StOk;
        end
      end
      ppa_pkg::ST_UN_EV: begin
        // Successor inside the run: fetch its own successor to bridge it.
        link_raddr = link_rdata_q[PW-1:0];
        if (!nxt_in_run) node_d = link_rdata_q;
      end
      ppa_pkg::ST_SK_EV: begin
        link_we    = 1'b1;
        link_waddr = node_q[PW-1:0];
        link_wdata = link_rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppa_pkg::ST_CLEAR;
      usable_q    <= ppa_pkg::UsablePagesReset;
      kfirst_q    <= ppa_pkg::KernelFirstReset;
      klast_q     <= ppa_pkg::KernelLastReset;
      head_q      <= ListEmpty;
      total_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      total_q <= total_d;
      ptr_q   <= ptr_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          ppa_pkg::RegUsablePages: usable_q <= cfg_data_i;
          ppa_pkg::RegKernelFirst: kfirst_q <= cfg_data_i[ppa_pkg::PageW-1:0];
          ppa_pkg::RegKernelLast:  klast_q  <= cfg_data_i[ppa_pkg::PageW-1:0];
          default: ;
        endcase
      end
      if (state_q == ppa_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    start_q <= start_d;
    end_q   <= end_d;
    node_q  <= node_d;
    st_q    <= st_d;
    rp_q    <= rp_d;
    if (accept) begin
      cmd_q   <= s_axis_tuser_i;
      page_q  <= s_axis_tdata_i[11:0];
      count_q <= WW'(s_axis_tdata_i[24:12]);
    end
    if (state_q == ppa_pkg::ST_DONE && out_free) begin
      out_status_q <= st_q;
      out_page_q   <= ppa_pkg::PageW'(rp_q);
      out_count_q  <= ppa_pkg::CountW'(total_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata_q <= link_mem[link_raddr];
  end

  `ASSERT_CLKD(a_total_bounded, total_q <= ListEmpty, "free page total exceeds page count")
  `ASSERT_CLKD(a_accept_leaves_idle, accept |=> state_q != ppa_pkg::ST_IDLE, "command beat not started")
  `ASSERT_CLKD(a_fail_page_zero, (m_axis_tvalid_o && m_axis_tuser_o != ppa_pkg::StOk) |-> m_axis_tdata_o[11:0] == '0, "failed result carries a page")
  `ASSERT_ALWAYS(a_no_take_in_clear, state_q == ppa_pkg::ST_CLEAR |-> !accept, "command taken during map clearing")

endmodule

`default_nettype wire

// File: tb/sv/tb_physical_page_allocator_top.sv
`timescale 1ns / 1ps

module tb_physical_page_allocator_top;

  localparam int Pages      = 4096;
  localparam int StallLimit = 200000;

  // Command code outside the defined set.
  localparam logic [ppa_pkg::CmdW-1:0] CmdUnknown = 2'd3;

  typedef struct packed {
    logic [ppa_pkg::StatusW-1:0] status;
    logic [ppa_pkg::PageW-1:0]   page;
    logic [ppa_pkg::CountW-1:0]  free;
  } alloc_result_t;

  typedef struct {
    logic [ppa_pkg::CmdW-1:0]   cmd;
    logic [ppa_pkg::PageW-1:0]  page;
    logic [ppa_pkg::CountW-1:0] count;
    bit                         known;
    alloc_result_t              res;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;

  physical_page_allocator_top dut (.*);

  // Shadow of the allocator state, kept in step with accepted command beats.
  bit          shadow_map [Pages];
  logic [12:0] shadow_link [Pages];
  logic [12:0] shadow_head;
  logic [12:0] shadow_total;
  logic [12:0] shadow_usable;
  logic [11:0] shadow_kfirst;
  logic [11:0] shadow_klast;

  alloc_result_t awaited_results[$];
  logic [11:0]   taken_pages[$];
  int            mismatches;
  int            results_seen;
  bit            calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void predict_alloc(input logic [1:0] c, input logic [11:0] pg,
                                        input logic [12:0] cnt, output alloc_result_t r);
    int lim;
    int run;
    int start;
    int p;
    logic [12:0] nd;
    logic [12:0] nx;
    bit reserved;
    r.status = ppa_pkg::StRejected;
    r.page   = '0;
    if (c == ppa_pkg::CmdAdd || c == ppa_pkg::CmdFree) begin
      reserved = (pg == 0) || (pg >= ppa_pkg::IsaFirstPage && pg <= ppa_pkg::IsaLastPage) ||
                 (pg >= shadow_kfirst && pg <= shadow_klast);
      if (!shadow_map[pg] && (c == ppa_pkg::CmdFree || !reserved)) begin
        shadow_link[pg] = shadow_head;
        shadow_head     = {1'b0, pg};
        shadow_map[pg]  = 1'b1;
        shadow_total++;
        r.status = ppa_pkg::StOk;
      end
    end else if (c == ppa_pkg::CmdAlloc) begin
      if (shadow_head == Pages) begin
        r.status = ppa_pkg::StOutOfMem;
      end else if (cnt == 1) begin
        r.page = shadow_head[11:0];
        shadow_map[shadow_head] = 1'b0;
        shadow_head = shadow_link[shadow_head];
        shadow_total--;
        r.status = ppa_pkg::StOk;
      end else begin
        lim = (shadow_usable > Pages) ? Pages : shadow_usable;
        run = 0;
        start = 0;
        r.status = ppa_pkg::StNoRun;
        for (p = 0; p < lim; p++) begin
          if (!shadow_map[p]) begin
            run = 0;
          end else begin
            if (run == 0) start = p;
            run++;
            if (run == cnt) begin
              for (int q = start; q <= p; q++) shadow_map[q] = 1'b0;
              // Take the whole run out of the list, the head included.
              while (shadow_head != Pages && shadow_head >= start && shadow_head <= p)
                shadow_head = shadow_link[shadow_head];
              nd = shadow_head;
              while (nd != Pages) begin
                nx = shadow_link[nd];
                if (nx != Pages && nx >= start && nx <= p) shadow_link[nd] = shadow_link[nx];
                else nd = nx;
              end
              shadow_total -= cnt;
              r.page = start[11:0];
              r.status = ppa_pkg::StOk;
              break;
            end
          end
        end
      end
    end
    r.free = shadow_total;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      got = '{m_axis_tuser_o, m_axis_tdata_o[11:0], m_axis_tdata_o[24:12]};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.page !== want.page ||
            got.free !== want.free) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status %0d page %0d free %0d, got %0d %0d %0d",
                     want.status, want.page, want.free, got.status, got.page, got.free);
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off.
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && results_seen >= 200) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // Watchdog on cycles with no handshake anywhere.
  always @(posedge clk_i) begin
    int quiet;
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else if (rst_ni) begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ppa_pkg::RegUsablePages: shadow_usable = val;
      ppa_pkg::RegKernelFirst: shadow_kfirst = val[11:0];
      ppa_pkg::RegKernelLast:  shadow_klast  = val[11:0];
      default: ;
    endcase
  endtask

  task automatic issue_cmd(input logic [1:0] c, input logic [11:0] pg, input logic [12:0] cnt,
                           input bit known, input alloc_result_t typed);
    alloc_result_t r;
    if (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= c;
    s_axis_tdata_i  <= {7'd0, cnt, pg};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_alloc(c, pg, cnt, r);
    if (r.status == ppa_pkg::StOk && c == ppa_pkg::CmdAlloc)
      for (int i = 0; i < ((cnt == 1) ? 1 : cnt); i++) taken_pages.push_back(12'(r.page + i));
    awaited_results.push_back(known ? typed : r);
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  cmd_row_t directed[] = '{
    '{ppa_pkg::CmdAlloc, 12'd0,    13'd1,    1, '{ppa_pkg::StOutOfMem, 12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd0,    13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd160,  13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd255,  13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd256,  13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd511,  13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd4095, 13'd8191, 1, '{ppa_pkg::StOk,       12'd0, 13'd1}},
    '{ppa_pkg::CmdAdd,   12'd4095, 13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd1}},
    '{ppa_pkg::CmdFree,  12'd4095, 13'd0,    1, '{ppa_pkg::StRejected, 12'd0, 13'd1}},
    '{CmdUnknown,        12'd5,    13'd1,    1, '{ppa_pkg::StRejected, 12'd0, 13'd1}},
    '{ppa_pkg::CmdAlloc, 12'd0,    13'd0,    1, '{ppa_pkg::StNoRun,    12'd0, 13'd1}},
    '{ppa_pkg::CmdAlloc, 12'd4095, 13'd4096, 1, '{ppa_pkg::StNoRun,    12'd0, 13'd1}},
    '{ppa_pkg::CmdAlloc, 12'd0,    13'd1,    1, '{ppa_pkg::StOk,       12'd4095, 13'd0}},
    '{ppa_pkg::CmdFree,  12'd200,  13'd0,    1, '{ppa_pkg::StOk,       12'd0, 13'd1}},
    '{ppa_pkg::CmdAdd,   12'd1,    13'd0,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd2,    13'd0,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd3,    13'd0,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAlloc, 12'd0,    13'd3,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd512,  13'd0,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd159,  13'd0,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAdd,   12'd158,  13'd0,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAlloc, 12'd0,    13'd2,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdAlloc, 12'd0,    13'd1,    0, '{ppa_pkg::StOk,       12'd0, 13'd0}},
    '{ppa_pkg::CmdFree,  12'd4095, 13'd0,    1, '{ppa_pkg::StOk,       12'd0, 13'd2}},
    '{ppa_pkg::CmdAdd,   12'd4094, 13'd0,    1, '{ppa_pkg::StOk,       12'd0, 13'd3}}
  };

  // Settings per random phase: usable pages, kernel first, kernel last, beats.
  int phase_usable[] = '{256, 0, 600, 4096, 8191, 300, 128, 700, 64, 400};
  int phase_kfirst[] = '{300, 4095, 500, 0, 0, 700, 0, 1000, 4095, 2000};
  int phase_klast[]  = '{400, 4095, 20, 0, 4095, 900, 4095, 1500, 0, 2100};
  int phase_beats[]  = '{150, 100, 150, 40, 30, 170, 100, 150, 130, 130};

  initial begin
    alloc_result_t none;
    logic [1:0]  c;
    logic [11:0] pg;
    logic [12:0] cnt;
    int          lo;
    int          pick;
    none = '0;
    calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    foreach (shadow_map[i]) shadow_map[i] = 1'b0;
    shadow_head   = 13'(Pages);
    shadow_total  = '0;
    shadow_usable = ppa_pkg::UsablePagesReset;
    shadow_kfirst = ppa_pkg::KernelFirstReset;
    shadow_klast  = ppa_pkg::KernelLastReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      issue_cmd(directed[i].cmd, directed[i].page, directed[i].count, directed[i].known,
                directed[i].res);

    foreach (phase_beats[ph]) begin
      // Registers change only once the allocator has gone quiet.
      drain();
      write_reg(ppa_pkg::RegUsablePages, 13'(phase_usable[ph]));
      write_reg(ppa_pkg::RegKernelFirst, 13'(phase_kfirst[ph]));
      write_reg(ppa_pkg::RegKernelLast, 13'(phase_klast[ph]));
      calm = (ph == 5);
      lo = $urandom_range(3840);
      repeat (phase_beats[ph]) begin
        pick = $urandom_range(99);
        cnt  = 13'($urandom_range(8191));
        pg   = ($urandom_range(99) < 85) ? 12'(lo + $urandom_range(255))
                                         : 12'($urandom_range(4095));
        if (pick < 3) begin
          c = CmdUnknown;
        end else if (pick < ((shadow_total > 150) ? 15 : 45)) begin
          c = ppa_pkg::CmdAdd;
        end else if (pick < ((shadow_total > 150) ? 35 : 65)) begin
          c = ppa_pkg::CmdFree;
          if (taken_pages.size() != 0 && $urandom_range(99) < 70) begin
            pick = $urandom_range(taken_pages.size() - 1);
            pg = taken_pages[pick];
            taken_pages.delete(pick);
          end
        end else begin
          c = ppa_pkg::CmdAlloc;
          pick = $urandom_range(99);
          if (pick < 50) cnt = 13'd1;
          else if (pick < 90) cnt = 13'($urandom_range(8, 2));
          else if (pick < 97) cnt = 13'($urandom_range(64, 9));
          else if (pick == 97) cnt = 13'd0;
          else if (pick == 98) cnt = 13'd4096;
        end
        issue_cmd(c, pg, cnt, 1'b0, none);
      end
    end
    calm = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
